>>> rtl/bcr_pkg.sv
// Shared constants and types for the bicubic axis resampler.
`timescale 1ns / 1ps

package bcr_pkg;

  // Fixed-point format and store geometry
  localparam int MAX_LEN   = 4096;
  localparam int LEN_W     = 13;
  localparam int IDX_W     = 12;
  localparam int PX_W      = 8;
  localparam int FRAC_BITS = 16;
  localparam int PREC_BITS = 22;

  // Datapath widths
  localparam int CEN_W   = 29;   // centre position, Q.16
  localparam int SUP_W   = 30;   // support, Q.16
  localparam int DIST_W  = 29;   // tap distance, Q.16
  localparam int MAG_W   = 17;   // kernel magnitude, up to 1.0
  localparam int SUM_W   = 30;   // signed span sum
  localparam int DIV_N_W = 42;   // dividend / quotient
  localparam int DIV_D_W = 30;   // divisor
  localparam int WGT_W   = 41;   // signed tap weight
  localparam int ACC_W   = 62;   // signed channel accumulator

  // Input item codes
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

  // Register map (index taken from paddr[2])
  localparam logic REG_SOURCE_LENGTH = 1'b0;
  localparam logic REG_TARGET_LENGTH = 1'b1;

  // Control to the channel lanes
  typedef struct packed {
    logic init;
    logic acc_en;
  } lane_ctrl_t;

  // Control to the merging stage
  typedef struct packed {
    logic load;
    logic err;
  } merge_ctrl_t;

endpackage

>>> rtl/bcr_divider.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bcr_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bcr_pkg::DIV_N_W-1:0] dividend,
  input  logic [bcr_pkg::DIV_D_W-1:0] divisor,
  output logic                        busy,
  output logic                        done,
  output logic [bcr_pkg::DIV_N_W-1:0] quotient
);

  localparam int CNT_W = $clog2(bcr_pkg::DIV_N_W);

  logic [bcr_pkg::DIV_N_W-1:0] num;
  logic [bcr_pkg::DIV_D_W-1:0] den;
  logic [bcr_pkg::DIV_D_W-1:0] rem;
  logic [CNT_W-1:0]            cnt;
  logic [bcr_pkg::DIV_D_W:0]   rem_sh;
  logic                        ge;
  logic [bcr_pkg::DIV_D_W-1:0] rem_next;

  // One restoring step
  always_comb begin
    rem_sh   = {rem, num[bcr_pkg::DIV_N_W-1]};
    ge       = rem_sh >= {1'b0, den};
    rem_next = ge ? bcr_pkg::DIV_D_W'(rem_sh - {1'b0, den})
                  : bcr_pkg::DIV_D_W'(rem_sh);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(bcr_pkg::DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operands; quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      num <= {num[bcr_pkg::DIV_N_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient = num;

endmodule

>>> rtl/bcr_lane.sv
// One colour channel lane: weighted pixel accumulation.
`timescale 1ns / 1ps

module bcr_lane (
  input  logic                             clk,
  input  bcr_pkg::lane_ctrl_t              ctrl,
  input  logic [bcr_pkg::PX_W-1:0]         pixel,
  input  logic signed [bcr_pkg::WGT_W-1:0] weight,
  output logic signed [bcr_pkg::ACC_W-1:0] acc
);

  logic signed [bcr_pkg::WGT_W+bcr_pkg::PX_W:0] prod;

  assign prod = $signed({1'b0, pixel}) * weight;

  // Start at half a unit, then add one tap per strobe
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      acc <= bcr_pkg::ACC_W'(1) <<< (bcr_pkg::PREC_BITS - 1);
    end else if (ctrl.acc_en) begin
      acc <= acc + bcr_pkg::ACC_W'(prod);
    end
  end

endmodule

>>> rtl/bcr_merge.sv
// Merging stage: clamps the three lane sums into the output register.
`timescale 1ns / 1ps

module bcr_merge (
  input  logic                             clk,
  input  logic                             rst,
  input  bcr_pkg::merge_ctrl_t             ctrl,
  input  logic signed [bcr_pkg::ACC_W-1:0] acc_red,
  input  logic signed [bcr_pkg::ACC_W-1:0] acc_green,
  input  logic signed [bcr_pkg::ACC_W-1:0] acc_blue,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [bcr_pkg::PX_W-1:0]         out_red,
  output logic [bcr_pkg::PX_W-1:0]         out_green,
  output logic [bcr_pkg::PX_W-1:0]         out_blue,
  output logic                             index_error
);

  // Non-positive gives 0, else shift down and saturate
  function automatic logic [bcr_pkg::PX_W-1:0] clamp_px(
    input logic signed [bcr_pkg::ACC_W-1:0] v
  );
    logic [bcr_pkg::ACC_W-bcr_pkg::PREC_BITS-1:0] hi;
    hi = v[bcr_pkg::ACC_W-1:bcr_pkg::PREC_BITS];
    if (v <= 0) begin
      clamp_px = '0;
    end else if (hi > (bcr_pkg::ACC_W-bcr_pkg::PREC_BITS)'(255)) begin
      clamp_px = 8'hFF;
    end else begin
      clamp_px = hi[bcr_pkg::PX_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      index_error <= ctrl.err;
      out_red     <= ctrl.err ? '0 : clamp_px(acc_red);
      out_green   <= ctrl.err ? '0 : clamp_px(acc_green);
      out_blue    <= ctrl.err ? '0 : clamp_px(acc_blue);
    end
  end

endmodule

>>> rtl/bicubic_axis_resampler.sv
// Top level of the bicubic axis resampler: sequencer, line store, lanes.
`timescale 1ns / 1ps

// A load transaction writes one pixel into the 4096-entry line store. A compute
// transaction walks its tap span twice (once if the kernel sum is not positive)
// through one shared divider: centre division, support division when
// downscaling, then for the sum pass a kernel evaluation per tap and for the
// weighting pass a kernel evaluation and a weight division per tap, each tap
// adding a division in both passes when downscaling for the distance scaling.
// Upscaling spans at most four taps. The three colour channels run as parallel
// lanes and a merging stage clamps them into the output register, so the
// next transaction is taken while a result waits.

module bicubic_axis_resampler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic [bcr_pkg::IDX_W-1:0]   source_index,
  input  logic [bcr_pkg::PX_W-1:0]    in_red,
  input  logic [bcr_pkg::PX_W-1:0]    in_green,
  input  logic [bcr_pkg::PX_W-1:0]    in_blue,
  input  logic [bcr_pkg::IDX_W-1:0]   target_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bcr_pkg::PX_W-1:0]    out_red,
  output logic [bcr_pkg::PX_W-1:0]    out_green,
  output logic [bcr_pkg::PX_W-1:0]    out_blue,
  output logic                        index_error
);

  localparam int LW = bcr_pkg::LEN_W;
  localparam int FB = bcr_pkg::FRAC_BITS;
  localparam logic [bcr_pkg::DIST_W-1:0] ONE = bcr_pkg::DIST_W'(1) << FB;
  localparam logic [bcr_pkg::DIST_W-1:0] TWO = bcr_pkg::DIST_W'(2) << FB;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DCEN  = 10'b0000000010,
    S_DSUP  = 10'b0000000100,
    S_SPAN  = 10'b0000001000,
    S_TAP   = 10'b0000010000,
    S_DTAP  = 10'b0000100000,
    S_KER1  = 10'b0001000000,
    S_KER2  = 10'b0010000000,
    S_DWGT  = 10'b0100000000,
    S_FINAL = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [LW-1:0] src_len, tgt_len;
  logic          acc_in, down;

  // Item registers
  logic                                err_r, pass, kneg;
  logic [bcr_pkg::CEN_W-1:0]           center;
  logic [bcr_pkg::SUP_W-1:0]           support;
  logic [LW-1:0]                       tap_first, tap_end, tap_i;
  logic [bcr_pkg::DIST_W-1:0]          x;
  logic [bcr_pkg::MAG_W-1:0]           p;
  logic signed [bcr_pkg::SUM_W-1:0]    sum;

  // Line store
  logic [3*bcr_pkg::PX_W-1:0] mem [bcr_pkg::MAX_LEN];
  logic [3*bcr_pkg::PX_W-1:0] mem_rd;

  // Divider hookup
  logic                         div_start, div_busy, div_done;
  logic [bcr_pkg::DIV_N_W-1:0]  div_n, div_q;
  logic [bcr_pkg::DIV_D_W-1:0]  div_d;

  bcr_pkg::lane_ctrl_t  lane_c;
  bcr_pkg::merge_ctrl_t mrg_c;
  logic signed [bcr_pkg::ACC_W-1:0] acc_r, acc_g, acc_b;
  logic signed [bcr_pkg::WGT_W-1:0] weight;

  // Combinational datapath
  logic [LW-1:0]              odd;
  logic [2*LW-1:0]            cen_prod;
  logic signed [31:0]         lo, hi;
  logic [LW-1:0]              first_c, end_c;
  logic signed [bcr_pkg::DIST_W:0] n_s;
  logic [bcr_pkg::DIST_W-1:0] m;
  logic [bcr_pkg::DIV_N_W-1:0] mt;
  logic [bcr_pkg::MAG_W-1:0]  ka;
  logic [2*bcr_pkg::MAG_W-1:0] sq;
  logic [18:0]                c5;
  logic [35:0]                pn;
  logic [32:0]                pf;
  logic [18:0]                qn;
  logic                       near, far;
  logic [bcr_pkg::MAG_W-1:0]  mag;
  logic signed [bcr_pkg::SUM_W-1:0] kval;

  // Configuration port
  function automatic logic [LW-1:0] clamp_len(input logic [LW-1:0] v);
    if (v == '0) begin
      clamp_len = LW'(1);
    end else if (v > LW'(bcr_pkg::MAX_LEN)) begin
      clamp_len = LW'(bcr_pkg::MAX_LEN);
    end else begin
      clamp_len = v;
    end
  endfunction

  assign pready = 1'b1;
  assign prdata = (paddr[2] == bcr_pkg::REG_TARGET_LENGTH) ? 32'(tgt_len) : 32'(src_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_len <= LW'(1);
      tgt_len <= LW'(1);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == bcr_pkg::REG_SOURCE_LENGTH) begin
        src_len <= clamp_len(pwdata[LW-1:0]);
      end else begin
        tgt_len <= clamp_len(pwdata[LW-1:0]);
      end
    end
  end

  assign in_stall = (state != S_IDLE);
  assign acc_in   = in_valid && !in_stall;
  assign down     = src_len > tgt_len;

  // Span arithmetic
  always_comb begin
    odd      = {target_index, 1'b1};
    cen_prod = odd * src_len;
    lo = $signed({3'b0, center}) - $signed({2'b0, support}) + 32'sd32768;
    hi = $signed({3'b0, center}) + $signed({2'b0, support}) + 32'sd32768;
    first_c = (lo <= 0) ? '0 : lo[LW+FB-1:FB];
    end_c   = ({1'b0, hi[LW+FB:FB]} > {1'b0, src_len}) ? src_len : hi[LW+FB-1:FB];
    n_s = $signed({1'b0, tap_i[LW-2:0], 1'b1, (FB-1)'(0)}) - $signed({1'b0, center});
    m   = n_s[bcr_pkg::DIST_W] ? bcr_pkg::DIST_W'(-n_s) : n_s[bcr_pkg::DIST_W-1:0];
    mt  = m * tgt_len;
  end

  // Kernel arithmetic
  always_comb begin
    near = x < ONE;
    far  = !near && (x < TWO);
    ka   = near ? x[bcr_pkg::MAG_W-1:0] : bcr_pkg::MAG_W'(TWO - x);
    sq   = ka * ka;
    c5   = 19'(5 * (1 << FB)) - 19'(3 * x[FB-1:0]);
    pn   = p * c5;
    pf   = (x[FB-1:0]) * p;
    qn   = pn[35:FB+1];
    if (near) begin
      mag = (qn >= 19'(ONE)) ? '0 : bcr_pkg::MAG_W'(19'(ONE) - qn);
    end else if (far) begin
      mag = bcr_pkg::MAG_W'(pf[32:FB+1]);
    end else begin
      mag = '0;
    end
    kval = far ? -$signed(bcr_pkg::SUM_W'(mag)) : $signed(bcr_pkg::SUM_W'(mag));
  end

  assign weight = kneg ? -$signed(div_q[bcr_pkg::WGT_W-1:0])
                       : $signed(div_q[bcr_pkg::WGT_W-1:0]);

  // Sequencer
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_n      = '0;
    div_d      = '0;
    lane_c     = '0;
    mrg_c      = '0;
    unique case (state)
      S_IDLE: begin
        if (acc_in && mode == bcr_pkg::MODE_COMPUTE) begin
          if ({1'b0, target_index} < tgt_len) begin
            div_start  = 1'b1;
            div_n      = {cen_prod, FB'(0)};
            div_d      = bcr_pkg::DIV_D_W'({tgt_len, 1'b0});
            state_next = S_DCEN;
          end else begin
            state_next = S_FINAL;
          end
        end
      end
      S_DCEN: begin
        if (div_done) begin
          if (down) begin
            div_start  = 1'b1;
            div_n      = bcr_pkg::DIV_N_W'({src_len, 1'b0, FB'(0)});
            div_d      = bcr_pkg::DIV_D_W'(tgt_len);
            state_next = S_DSUP;
          end else begin
            state_next = S_SPAN;
          end
        end
      end
      S_DSUP: begin
        if (div_done) state_next = S_SPAN;
      end
      S_SPAN: begin
        lane_c.init = 1'b1;
        state_next  = S_TAP;
      end
      S_TAP: begin
        if (tap_i >= tap_end) begin
          if (pass || sum <= 0) state_next = S_FINAL;
        end else if (down) begin
          div_start  = 1'b1;
          div_n      = mt;
          div_d      = bcr_pkg::DIV_D_W'(src_len);
          state_next = S_DTAP;
        end else begin
          state_next = S_KER1;
        end
      end
      S_DTAP: begin
        if (div_done) state_next = S_KER1;
      end
      S_KER1: begin
        state_next = S_KER2;
      end
      S_KER2: begin
        if (pass) begin
          div_start  = 1'b1;
          div_n      = (bcr_pkg::DIV_N_W'(mag) << (bcr_pkg::PREC_BITS + 1))
                     + bcr_pkg::DIV_N_W'(sum[bcr_pkg::SUM_W-2:0]);
          div_d      = {sum[bcr_pkg::SUM_W-2:0], 1'b0};
          state_next = S_DWGT;
        end else begin
          state_next = S_TAP;
        end
      end
      S_DWGT: begin
        if (div_done) begin
          lane_c.acc_en = 1'b1;
          state_next    = S_TAP;
        end
      end
      S_FINAL: begin
        if (!(out_valid && out_stall)) begin
          mrg_c.load = 1'b1;
          mrg_c.err  = err_r;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= 1'b0;
      err_r <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && acc_in) begin
        pass  <= 1'b0;
        err_r <= !({1'b0, target_index} < tgt_len);
      end else if (state == S_TAP && tap_i >= tap_end && !pass && sum > 0) begin
        pass <= 1'b1;
      end
    end
  end

  // Item datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_DCEN: begin
        if (div_done) begin
          center  <= div_q[bcr_pkg::CEN_W-1:0];
          support <= bcr_pkg::SUP_W'(TWO);
        end
      end
      S_DSUP: begin
        if (div_done) support <= div_q[bcr_pkg::SUP_W-1:0];
      end
      S_SPAN: begin
        tap_first <= first_c;
        tap_i     <= first_c;
        tap_end   <= end_c;
        sum       <= '0;
      end
      S_TAP: begin
        if (tap_i >= tap_end) begin
          tap_i <= tap_first;
        end else begin
          x <= m;
        end
      end
      S_DTAP: begin
        if (div_done) x <= div_q[bcr_pkg::DIST_W-1:0];
      end
      S_KER1: begin
        p <= sq[bcr_pkg::MAG_W+FB-1:FB];
      end
      S_KER2: begin
        kneg <= far;
        if (!pass) begin
          sum   <= sum + kval;
          tap_i <= tap_i + 1'b1;
        end
      end
      S_DWGT: begin
        if (div_done) tap_i <= tap_i + 1'b1;
      end
      default: ;
    endcase
  end

  // Line store: loads in idle, one registered read per tap
  always_ff @(posedge clk) begin
    if (acc_in && mode == bcr_pkg::MODE_LOAD) begin
      mem[source_index] <= {in_red, in_green, in_blue};
    end
    if (state == S_TAP) begin
      mem_rd <= mem[tap_i[bcr_pkg::IDX_W-1:0]];
    end
  end

  bcr_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  bcr_lane u_lane_r (
    .clk(clk), .ctrl(lane_c), .pixel(mem_rd[23:16]), .weight(weight), .acc(acc_r)
  );
  bcr_lane u_lane_g (
    .clk(clk), .ctrl(lane_c), .pixel(mem_rd[15:8]), .weight(weight), .acc(acc_g)
  );
  bcr_lane u_lane_b (
    .clk(clk), .ctrl(lane_c), .pixel(mem_rd[7:0]), .weight(weight), .acc(acc_b)
  );

  bcr_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (mrg_c),
    .acc_red     (acc_r),
    .acc_green   (acc_g),
    .acc_blue    (acc_b),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .index_error (index_error)
  );

  // Divider is never restarted mid-operation
  a_div_free: assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider started while busy");

  // A result never overwrites one still held by a stalled consumer
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    mrg_c.load |-> !(out_valid && out_stall))
    else $error("output register overrun");

  // Kernel evaluation only for taps inside the span
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_KER1) |-> (tap_i < tap_end))
    else $error("kernel evaluated outside span");

  // A compute transaction holds off the input channel
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    (acc_in && mode == bcr_pkg::MODE_COMPUTE) |=> in_stall)
    else $error("input accepted during compute");

endmodule

>>> tb/bicubic_axis_resampler_tb.sv
// Self-checking testbench for the bicubic axis resampler: driver, monitor and pixel predictor.
`timescale 1ns / 1ps

module bicubic_axis_resampler_tb;

  localparam longint KQ = 64'sd1 << bcr_pkg::FRAC_BITS;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct {
    logic                      mode;
    logic [bcr_pkg::IDX_W-1:0] sidx;
    logic [bcr_pkg::PX_W-1:0]  red, green, blue;
    logic [bcr_pkg::IDX_W-1:0] tidx;
  } item_t;

  typedef struct {
    logic [bcr_pkg::PX_W-1:0] red, green, blue;
    logic                     err;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = bcr_pkg::MODE_LOAD;
  logic [bcr_pkg::IDX_W-1:0] source_index = '0, target_index = '0;
  logic [bcr_pkg::PX_W-1:0]  in_red = '0, in_green = '0, in_blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [bcr_pkg::PX_W-1:0] out_red, out_green, out_blue;
  logic index_error;

  // Predictor state: its own line store and lengths
  logic [23:0] pix_store [bcr_pkg::MAX_LEN];
  longint src_len = 1, tgt_len = 1;
  // Entries already scheduled for loading, tracked at generation time
  bit written [bcr_pkg::MAX_LEN];

  item_t  pending_items[$];
  pixel_t expected_pixels[$];
  int mismatches = 0;
  int items_made = 0;
  int hold_requests = 0;
  int idle_count = 0;

  bicubic_axis_resampler u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Length register as the block interprets it
  function automatic longint clamp_len(input logic [31:0] v);
    longint m;
    m = v & 32'h1FFF;
    if (m == 0) return 1;
    if (m > bcr_pkg::MAX_LEN) return bcr_pkg::MAX_LEN;
    return m;
  endfunction

  // Centre and tap span of output pixel t
  function automatic void tap_span(input longint t, output longint c_q, output longint lo_tap,
                                   output longint hi_tap);
    longint sup, l, h;
    c_q = ((2 * t + 1) * src_len * KQ) / (2 * tgt_len);
    sup = (src_len > tgt_len) ? (2 * src_len * KQ) / tgt_len : 2 * KQ;
    l = c_q - sup + KQ / 2;
    h = c_q + sup + KQ / 2;
    lo_tap = (l <= 0) ? 0 : l / KQ;
    hi_tap = (h <= 0) ? 0 : h / KQ;
    if (hi_tap > src_len) hi_tap = src_len;
  endfunction

  // Signed Q2.16 bicubic weight (a = -0.5) of tap i
  function automatic longint cubic_weight(input longint i, input longint c_q);
    longint n, x, p, q, mag;
    bit neg;
    n = i * KQ + KQ / 2 - c_q;
    x = (n < 0) ? -n : n;
    if (src_len > tgt_len) x = x * tgt_len / src_len;
    neg = 1'b0;
    if (x < KQ) begin
      p = (x * x) >>> bcr_pkg::FRAC_BITS;
      q = (p * (5 * KQ - 3 * x)) >>> (bcr_pkg::FRAC_BITS + 1);
      mag = (q >= KQ) ? 0 : KQ - q;
    end else if (x < 2 * KQ) begin
      p = ((2 * KQ - x) * (2 * KQ - x)) >>> bcr_pkg::FRAC_BITS;
      mag = ((x - KQ) * p) >>> (bcr_pkg::FRAC_BITS + 1);
      neg = 1'b1;
    end else begin
      return 0;
    end
    mag = (mag <<< 16) >>> bcr_pkg::FRAC_BITS;
    return neg ? -mag : mag;
  endfunction

  // Expected output pixel for a compute transaction
  function automatic pixel_t resample(input longint t);
    pixel_t r;
    longint c_q, lo_tap, hi_tap, sum, kv, mag, w, v;
    longint acc [3];
    r = '{default: '0};
    if (t >= tgt_len) begin
      r.err = 1'b1;
      return r;
    end
    tap_span(t, c_q, lo_tap, hi_tap);
    sum = 0;
    for (longint i = lo_tap; i < hi_tap; i++) sum += cubic_weight(i, c_q);
    for (int c = 0; c < 3; c++) acc[c] = 64'sd1 << (bcr_pkg::PREC_BITS - 1);
    if (sum > 0) begin
      for (longint i = lo_tap; i < hi_tap; i++) begin
        kv = cubic_weight(i, c_q);
        mag = (kv < 0) ? -kv : kv;
        w = (mag * (64'sd1 << bcr_pkg::PREC_BITS) * 2 + sum) / (2 * sum);
        if (kv < 0) w = -w;
        acc[0] += longint'(pix_store[i][23:16]) * w;
        acc[1] += longint'(pix_store[i][15:8]) * w;
        acc[2] += longint'(pix_store[i][7:0]) * w;
      end
    end
    for (int c = 0; c < 3; c++) begin
      v = acc[c];
      if (v <= 0) v = 0;
      else begin
        v = v >>> bcr_pkg::PREC_BITS;
        if (v > 255) v = 255;
      end
      acc[c] = v;
    end
    r.red = acc[0][7:0];
    r.green = acc[1][7:0];
    r.blue = acc[2][7:0];
    return r;
  endfunction

  // Driver: one transaction at a time from the pending queue, random gaps
  int gap_left = 0;
  int sent = 0;
  always @(posedge clk) begin
    item_t it;
    bit busy;
    if (!rst) begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        busy = 1'b0;
        if (mode == bcr_pkg::MODE_LOAD) pix_store[source_index] <= {in_red, in_green, in_blue};
        else expected_pixels.insert(expected_pixels.size(), resample(target_index));
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          mode <= it.mode;
          source_index <= it.sidx;
          in_red <= it.red;
          in_green <= it.green;
          in_blue <= it.blue;
          target_index <= it.tidx;
          in_valid <= 1'b1;
          sent <= sent + 1;
          // alternate stretches with and without gaps
          gap_left <= sent[6] ? $urandom_range(0, 5) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation, random stalls
  int stall_left = 0;
  int hold_left = 0;
  int hold_seen = 0;
  always @(posedge clk) begin
    pixel_t exp_px;
    int n;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %0d %0d %0d err=%0b",
                                        out_red, out_green, out_blue, index_error);
        end else begin
          exp_px = expected_pixels.pop_front();
          if (out_red !== exp_px.red || out_green !== exp_px.green ||
              out_blue !== exp_px.blue || index_error !== exp_px.err) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected %0d %0d %0d err=%0b, got %0d %0d %0d err=%0b",
                       exp_px.red, exp_px.green, exp_px.blue, exp_px.err,
                       out_red, out_green, out_blue, index_error);
          end
        end
      end
      if (hold_requests != hold_seen) begin
        hold_seen <= hold_requests;
        hold_left <= 12000;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        n = sent[5] ? $urandom_range(0, 5) : 0;
        stall_left <= n;
        out_stall <= (n > 0);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= (stall_left > 1);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no accepted transaction, result or register access
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic reg_write(input logic reg_sel, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == bcr_pkg::REG_SOURCE_LENGTH) src_len = clamp_len(value);
    else tgt_len = clamp_len(value);
  endtask

  task automatic push_load(input int idx, input logic [23:0] rgb);
    item_t it;
    it.mode = bcr_pkg::MODE_LOAD;
    it.sidx = bcr_pkg::IDX_W'(idx);
    {it.red, it.green, it.blue} = rgb;
    it.tidx = bcr_pkg::IDX_W'($urandom);
    written[idx] = 1'b1;
    pending_items.insert(pending_items.size(), it);
    items_made++;
  endtask

  // Compute transaction, preceded by loads of any unwritten taps in its span
  task automatic push_compute(input int t);
    item_t it;
    longint c_q, lo_tap, hi_tap;
    if (t < tgt_len) begin
      tap_span(t, c_q, lo_tap, hi_tap);
      for (longint i = lo_tap; i < hi_tap; i++)
        if (!written[i]) push_load(int'(i), 24'($urandom));
    end
    it.mode = bcr_pkg::MODE_COMPUTE;
    it.sidx = bcr_pkg::IDX_W'($urandom);
    {it.red, it.green, it.blue} = 24'($urandom);
    it.tidx = bcr_pkg::IDX_W'(t);
    pending_items.insert(pending_items.size(), it);
    items_made++;
  endtask

  // Wait until the block is idle with nothing outstanding
  task automatic drain;
    while (pending_items.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic config_phase(input logic [31:0] s_val, input logic [31:0] t_val);
    drain();
    reg_write(bcr_pkg::REG_SOURCE_LENGTH, s_val);
    reg_write(bcr_pkg::REG_TARGET_LENGTH, t_val);
  endtask

  initial begin
    int s_rand, t_rand;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Upscale with extreme pixels, every target plus out-of-range ones
    config_phase(4, 8);
    push_load(0, 24'h000000);
    push_load(1, 24'hFFFFFF);
    push_load(2, 24'hFF00FF);
    push_load(3, 24'h00FF00);
    for (int t = 0; t < 9; t++) push_compute(t);
    push_compute(4095);
    // Downscale with ringing around sharp edges
    config_phase(8, 3);
    for (int t = 0; t < 4; t++) push_compute(t);
    // Zero lengths act as one
    config_phase(0, 0);
    push_compute(0);
    push_compute(1);
    // Oversized lengths clamp to the store size
    config_phase(8191, 4096);
    push_compute(0);
    push_compute(2048);
    push_compute(4095);
    config_phase(1, 4096);
    push_compute(0);
    push_compute(4095);
    config_phase(4096, 4095);
    push_compute(4094);
    push_compute(1);
    config_phase(64, 4);
    push_compute(0);
    push_compute(3);

    // Random phases with small lengths
    for (int ph = 0; items_made < 1950; ph++) begin
      s_rand = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
      t_rand = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
      if (s_rand > 8 * t_rand) s_rand = 8 * t_rand;
      config_phase(s_rand, t_rand);
      for (int n = 0; n < 60; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          push_load(int'($urandom_range(0, s_rand - 1)), 24'($urandom));
        end else if ($urandom_range(0, 9) == 0) begin
          push_compute(int'($urandom_range(0, 4095)));
        end else begin
          push_compute(int'($urandom_range(0, t_rand - 1)));
        end
      end
      // long receiver hold while the sender keeps offering
      if (ph == 3) hold_requests++;
    end

    drain();
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/bcr_pkg.sv
rtl/bcr_divider.sv
rtl/bcr_lane.sv
rtl/bcr_merge.sv
rtl/bicubic_axis_resampler.sv
tb/bicubic_axis_resampler_tb.sv
